@@ design/assert_macros.svh @@
// assertion helpers shared by the deframer and smoother modules
// expects clk and arst_n in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define FPDS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define FPDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/fpds_pkg.sv @@
// shared types, constants and scaling factors for the framed pair deframer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fpds_pkg;

	// history length of the moving average
	localparam int HISTORY_DEPTH = 3;
	localparam int SLOT_W        = $clog2(HISTORY_DEPTH);

	localparam int BYTE_W      = 8;
	localparam int STEER_W     = 14;
	localparam int COLL_W      = 10;
	localparam int CFG_IDX_W   = 8;

	// sum of the history and its q8 scaled form
	localparam int SUM_W    = $clog2(HISTORY_DEPTH * 255 + 1);
	localparam int SCALED_W = SUM_W + 8;

	// floor division by a constant as multiply by rounded-up reciprocal and shift,
	// exact for every scaled sum since the rounding error stays below one lsb
	localparam int STEER_DIV   = HISTORY_DEPTH * 10;
	localparam int STEER_SHIFT = SCALED_W + $clog2(STEER_DIV);
	localparam longint unsigned STEER_MUL =
		((64'd1 << STEER_SHIFT) + STEER_DIV - 1) / STEER_DIV;
	localparam int STEER_MUL_W  = STEER_SHIFT - $clog2(STEER_DIV) + 2;
	localparam int STEER_PROD_W = SCALED_W + STEER_MUL_W;

	localparam int COLL_DIV    = HISTORY_DEPTH * 100;
	localparam int COLL_SHIFT  = SCALED_W + $clog2(COLL_DIV);
	localparam longint unsigned COLL_MUL =
		((64'd1 << COLL_SHIFT) + COLL_DIV - 1) / COLL_DIV;
	localparam int COLL_MUL_W  = COLL_SHIFT - $clog2(COLL_DIV) + 2;
	localparam int COLL_PROD_W = SCALED_W + COLL_MUL_W;

	// steer offset of -2.0 in q8
	localparam logic [STEER_W-1:0] STEER_OFFSET = STEER_W'(512);

	// register reset values
	localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'd115;
	localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'd101;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_MARKER = 8'd0,
		REG_END_MARKER   = 8'd1
	} fpds_reg_t;

	// position within a frame: which byte is expected next
	typedef enum logic [1:0] {
		FP_HUNT,
		FP_STEER,
		FP_COLL,
		FP_END
	} fpds_frame_t;

	// good frame handed from the deframer to the smoother
	typedef struct packed {
		logic              push;
		logic [BYTE_W-1:0] steer;
		logic [BYTE_W-1:0] coll;
	} fpds_push_t;

	typedef struct packed {
		logic [BYTE_W-1:0] start_marker;
		logic [BYTE_W-1:0] end_marker;
	} fpds_markers_t;

endpackage

`default_nettype wire

@@ design/fpds_ifs.sv @@
// channel interfaces: received bytes, smoothed results, register writes
// depends on fpds_pkg
`timescale 1ns / 1ps
`default_nettype none

interface fpds_byte_if;
	logic                        valid;
	logic                        ready;
	logic [fpds_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fpds_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [fpds_pkg::STEER_W-1:0] steer_q8;
	logic [fpds_pkg::COLL_W-1:0]        collision_q8;

	modport source (output valid, output steer_q8, output collision_q8, input ready);
	modport sink   (input valid, input steer_q8, input collision_q8, output ready);
endinterface

interface fpds_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [fpds_pkg::CFG_IDX_W-1:0] index;
	logic [fpds_pkg::BYTE_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/framed_pair_deframer_smoother_core.sv @@
// Deframes start/steer/collision/end byte frames from a serial byte stream and
// produces a moving average of the last three good frames in q8 fixed point:
// steer_q8 = floor(sum*256/30) - 512 and collision_q8 = floor(sum*256/300).
// One byte word is accepted per clock unless the input register is held. An end
// byte passes the input register, the history update and the result register.
// Bytes that close no frame keep flowing while a result waits on the output;
// an end byte waits in the input register only when both the stage-two word and
// the result register are held. Histories reset to zero. Markers are written
// over the cfg channel (index 0 start marker, 1 end marker, others ignored),
// by the user only while idle (not enforced by the block); cfg is always ready.
// depends on fpds_pkg, fpds_ifs, fpds_deframer and fpds_smoother
`timescale 1ns / 1ps
`default_nettype none

module framed_pair_deframer_smoother_core (
	input  wire logic     clk,
	input  wire logic     arst_n,
	fpds_byte_if.sink     rx,
	fpds_result_if.source res,
	fpds_cfg_if.sink      cfg
);

	// marker registers
	fpds_pkg::fpds_markers_t markers_q;
	// good frame handed across, and back pressure from stage two
	fpds_pkg::fpds_push_t    push;
	logic                    s2_free;

	// register writes never stall
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			markers_q.start_marker <= fpds_pkg::START_MARKER_RST;
			markers_q.end_marker   <= fpds_pkg::END_MARKER_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				fpds_pkg::REG_START_MARKER: markers_q.start_marker <= cfg.data;
				fpds_pkg::REG_END_MARKER:   markers_q.end_marker   <= cfg.data;
				// unknown index, write dropped
				default: ;
			endcase
		end
	end

	// frame tracking on the registered byte
	fpds_deframer u_deframer (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.markers (markers_q),
		.s2_free (s2_free),
		.push    (push)
	);

	// histories, averaging and result register
	fpds_smoother u_smoother (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.s2_free (s2_free),
		.res     (res)
	);

endmodule

`default_nettype wire

@@ design/fpds_deframer.sv @@
// input register and frame position tracking, emits one push per good frame
// depends on fpds_pkg, fpds_ifs and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fpds_deframer (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	fpds_byte_if.sink                    rx,
	input  wire fpds_pkg::fpds_markers_t markers,
	input  wire logic                    s2_free,
	output fpds_pkg::fpds_push_t         push
);

	logic                        valid_s1;
	logic [fpds_pkg::BYTE_W-1:0] byte_s1;
	fpds_pkg::fpds_frame_t       state_q;
	fpds_pkg::fpds_frame_t       state_nxt;
	logic [fpds_pkg::BYTE_W-1:0] steer_q;
	logic [fpds_pkg::BYTE_W-1:0] coll_q;
	logic                        push_req;
	logic                        s1_go;

	// byte in the input register leaves unless it closes a frame and the smoother is busy
	always_comb begin
		push_req = valid_s1 && (state_q == fpds_pkg::FP_END) &&
			(byte_s1 == markers.end_marker);
		s1_go    = valid_s1 && (!push_req || s2_free);
		rx.ready = !valid_s1 || s1_go;
		push.push  = push_req && s2_free;
		push.steer = steer_q;
		push.coll  = coll_q;
	end

	always_comb begin
		state_nxt = state_q;
		if (s1_go) begin
			unique case (state_q)
				fpds_pkg::FP_HUNT: begin
					if (byte_s1 == markers.start_marker) begin
						state_nxt = fpds_pkg::FP_STEER;
					end
				end
				fpds_pkg::FP_STEER: state_nxt = fpds_pkg::FP_COLL;
				fpds_pkg::FP_COLL:  state_nxt = fpds_pkg::FP_END;
				// end byte, good or bad, always returns to hunting
				fpds_pkg::FP_END:   state_nxt = fpds_pkg::FP_HUNT;
				default:            state_nxt = fpds_pkg::FP_HUNT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= fpds_pkg::FP_HUNT;
		end else begin
			state_q <= state_nxt;
			if (rx.valid && rx.ready) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
		if (s1_go && (state_q == fpds_pkg::FP_STEER)) begin
			steer_q <= byte_s1;
		end
		if (s1_go && (state_q == fpds_pkg::FP_COLL)) begin
			coll_q <= byte_s1;
		end
	end

	`FPDS_ASSERT_NEXT(a_end_to_hunt, s1_go && (state_q == fpds_pkg::FP_END), state_q == fpds_pkg::FP_HUNT, "end byte did not return to hunting")
	`FPDS_ASSERT_NOW(a_push_at_end, push.push, state_q == fpds_pkg::FP_END, "push outside the end position")
	`FPDS_ASSERT_NEXT(a_hold_byte, valid_s1 && !s1_go, valid_s1 && $stable(byte_s1), "held byte lost")

endmodule

`default_nettype wire

@@ design/fpds_smoother.sv @@
// circular histories, sums and q8 scaling into the result register
// depends on fpds_pkg, fpds_ifs and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fpds_smoother (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire fpds_pkg::fpds_push_t push,
	output logic                      s2_free,
	fpds_result_if.source             res
);

	localparam logic [fpds_pkg::STEER_MUL_W-1:0] STEER_MUL_V =
		fpds_pkg::STEER_MUL_W'(fpds_pkg::STEER_MUL);
	localparam logic [fpds_pkg::COLL_MUL_W-1:0] COLL_MUL_V =
		fpds_pkg::COLL_MUL_W'(fpds_pkg::COLL_MUL);

	logic [fpds_pkg::BYTE_W-1:0]        steer_hist_q [fpds_pkg::HISTORY_DEPTH];
	logic [fpds_pkg::BYTE_W-1:0]        coll_hist_q  [fpds_pkg::HISTORY_DEPTH];
	logic [fpds_pkg::SLOT_W-1:0]        slot_q;
	logic                               valid_s2;
	logic                               out_valid_q;
	logic                               out_free;
	logic [fpds_pkg::SUM_W-1:0]         steer_sum;
	logic [fpds_pkg::SUM_W-1:0]         coll_sum;
	logic [fpds_pkg::STEER_PROD_W-1:0]  steer_prod;
	logic [fpds_pkg::COLL_PROD_W-1:0]   coll_prod;
	logic [fpds_pkg::STEER_PROD_W-1:0]  steer_quot;
	logic [fpds_pkg::COLL_PROD_W-1:0]   coll_quot;
	logic [fpds_pkg::STEER_W-1:0]       steer_res;
	logic [fpds_pkg::STEER_W-1:0]       steer_q;
	logic [fpds_pkg::COLL_W-1:0]        coll_q;

	assign out_free = !out_valid_q || res.ready;
	assign s2_free  = !valid_s2 || out_free;

	// stage two reads the histories as updated by the last push
	always_comb begin
		steer_sum = '0;
		coll_sum  = '0;
		for (int i = 0; i < fpds_pkg::HISTORY_DEPTH; i++) begin
			steer_sum = steer_sum + fpds_pkg::SUM_W'(steer_hist_q[i]);
			coll_sum  = coll_sum + fpds_pkg::SUM_W'(coll_hist_q[i]);
		end
		steer_prod = fpds_pkg::STEER_PROD_W'({steer_sum, 8'd0}) *
			fpds_pkg::STEER_PROD_W'(STEER_MUL_V);
		coll_prod  = fpds_pkg::COLL_PROD_W'({coll_sum, 8'd0}) *
			fpds_pkg::COLL_PROD_W'(COLL_MUL_V);
		steer_quot = steer_prod >> fpds_pkg::STEER_SHIFT;
		coll_quot  = coll_prod >> fpds_pkg::COLL_SHIFT;
		steer_res  = steer_quot[fpds_pkg::STEER_W-1:0] - fpds_pkg::STEER_OFFSET;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < fpds_pkg::HISTORY_DEPTH; i++) begin
				steer_hist_q[i] <= '0;
				coll_hist_q[i]  <= '0;
			end
		end else begin
			if (push.push) begin
				for (int i = 0; i < fpds_pkg::HISTORY_DEPTH; i++) begin
					if (slot_q == fpds_pkg::SLOT_W'(i)) begin
						steer_hist_q[i] <= push.steer;
						coll_hist_q[i]  <= push.coll;
					end
				end
				if (slot_q == fpds_pkg::SLOT_W'(fpds_pkg::HISTORY_DEPTH - 1)) begin
					slot_q <= '0;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
			if (push.push) begin
				valid_s2 <= 1'b1;
			end else if (out_free) begin
				valid_s2 <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			steer_q <= steer_res;
			coll_q  <= coll_quot[fpds_pkg::COLL_W-1:0];
		end
	end

	assign res.valid        = out_valid_q;
	assign res.steer_q8     = steer_q;
	assign res.collision_q8 = coll_q;

	`FPDS_ASSERT_NOW(a_push_room, push.push, s2_free, "push while stage two is held")
	`FPDS_ASSERT_NOW(a_out_source, $rose(out_valid_q), $past(valid_s2), "result without a stage two word")
	`FPDS_ASSERT_NOW(a_slot_range, 1'b1, slot_q <= fpds_pkg::SLOT_W'(fpds_pkg::HISTORY_DEPTH - 1), "history slot out of range")

endmodule

`default_nettype wire

@@ verif/framed_pair_deframer_smoother_core_test.sv @@
`timescale 1ns / 1ps
// self-checking bench for framed_pair_deframer_smoother_core: byte frames in, averages out
// depends on fpds_pkg, the fpds_ifs channel interfaces and the core rtl

module framed_pair_deframer_smoother_core_test;
	import fpds_pkg::*;

	// moving average shape, kept apart from the rtl package on purpose
	localparam int AVG_LEN     = 3;
	localparam int STEER_SCALE = 10;
	localparam int COLL_SCALE  = 100;
	localparam int STEER_BIAS  = 512;    // -2.0 in q8

	// marker values after reset, ascii s and e
	localparam logic [BYTE_W-1:0] OPEN_DEFAULT  = 8'h73;
	localparam logic [BYTE_W-1:0] CLOSE_DEFAULT = 8'h65;

	localparam int QUIET_LIMIT   = 500;  // cycles with no word moving on any channel
	localparam int SETTLE_CYCLES = 4;    // wait after the last average is in
	localparam int PHASE_WORDS   = 265;

	typedef struct {
		logic signed [STEER_W-1:0] steer;
		logic [COLL_W-1:0]         coll;
	} avg_t;

	logic clk;
	logic arst_n;

	fpds_byte_if   rx_if ();
	fpds_result_if res_if ();
	fpds_cfg_if    cfg_if ();

	framed_pair_deframer_smoother_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	// own copy of the deframer and smoother state
	fpds_frame_t       hunt_pos;
	logic [BYTE_W-1:0] held_steer;
	logic [BYTE_W-1:0] held_coll;
	logic [BYTE_W-1:0] open_mark;
	logic [BYTE_W-1:0] close_mark;
	logic [BYTE_W-1:0] steer_log [AVG_LEN];
	logic [BYTE_W-1:0] coll_log [AVG_LEN];
	int                log_slot;

	// averages still owed by the block, oldest first
	avg_t              avg_due [$];
	// bytes waiting to be sent
	logic [BYTE_W-1:0] byte_plan [$];

	bit byte_taken;      // set on the edge that takes a byte, cleared by the driver
	bit moved;
	int send_gap;
	int stall_left;
	int send_odds;       // one chance in this many of a sender gap, 0 for none
	int stall_odds;      // same for result stalls
	int quiet_cycles;
	int fails;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// steps the frame tracker by one byte and queues the average a good frame gives
	function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
		int   s_sum = 0;
		int   c_sum = 0;
		avg_t due;
		case (hunt_pos)
		FP_HUNT: begin
			// anything but the start marker is thrown away
			if (b == open_mark)
				hunt_pos = FP_STEER;
		end
		FP_STEER: begin
			// middle bytes are data even when they look like markers
			held_steer = b;
			hunt_pos = FP_COLL;
		end
		FP_COLL: begin
			held_coll = b;
			hunt_pos = FP_END;
		end
		default: begin
			// a bad end byte drops the frame and is not taken as a new start
			hunt_pos = FP_HUNT;
			if (b == close_mark) begin
				steer_log[log_slot] = held_steer;
				coll_log[log_slot] = held_coll;
				log_slot = (log_slot == AVG_LEN - 1) ? 0 : log_slot + 1;
				for (int i = 0; i < AVG_LEN; i++) begin
					s_sum += steer_log[i];
					c_sum += coll_log[i];
				end
				// floor of a non-negative scaled sum, then the steer offset
				due.steer = STEER_W'((s_sum * 256) / (AVG_LEN * STEER_SCALE) - STEER_BIAS);
				due.coll = COLL_W'((c_sum * 256) / (AVG_LEN * COLL_SCALE));
				avg_due.push_back(due);
			end
		end
		endcase
	endfunction

	// compares a result word with the oldest average owed
	function automatic void check_avg(input logic signed [STEER_W-1:0] steer,
			input logic [COLL_W-1:0] coll);
		avg_t due;
		if (avg_due.size() == 0) begin
			$display("%0t: result word with none owed, steer_q8 %0d collision_q8 %0d",
				$time, steer, coll);
			fails++;
		end else begin
			due = avg_due.pop_front();
			if (steer !== due.steer) begin
				$display("%0t: steer_q8 mismatch, expected %0d actual %0d",
					$time, due.steer, steer);
				fails++;
			end
			if (coll !== due.coll) begin
				$display("%0t: collision_q8 mismatch, expected %0d actual %0d",
					$time, due.coll, coll);
				fails++;
			end
		end
	endfunction

	// monitor: every handshake is seen at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_if.valid && cfg_if.ready) begin
				// other indexes are ignored by the block
				if (cfg_if.index == REG_START_MARKER)
					open_mark = cfg_if.data;
				else if (cfg_if.index == REG_END_MARKER)
					close_mark = cfg_if.data;
				moved = 1'b1;
			end
			if (rx_if.valid && rx_if.ready) begin
				deframe_byte(rx_if.rx_byte);
				byte_taken = 1'b1;
				moved = 1'b1;
			end
			if (res_if.valid && res_if.ready) begin
				check_avg(res_if.steer_q8, res_if.collision_q8);
				moved = 1'b1;
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
		end
	end

	// byte driver: holds a word until taken, with random gaps between words
	always @(negedge clk) begin
		if (arst_n) begin
			if (byte_taken || !rx_if.valid) begin
				byte_taken = 1'b0;
				if (send_gap > 0) begin
					rx_if.valid <= 1'b0;
					send_gap--;
				end else if (byte_plan.size() > 0) begin
					rx_if.valid <= 1'b1;
					rx_if.rx_byte <= byte_plan.pop_front();
					if (send_odds > 0 && $urandom_range(send_odds - 1, 0) == 0)
						send_gap = $urandom_range(10, 1);
				end else begin
					rx_if.valid <= 1'b0;
				end
			end
		end
	end

	// result sink: ready with random stall bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				res_if.ready <= 1'b0;
				stall_left--;
			end else begin
				res_if.ready <= 1'b1;
				if (stall_odds > 0 && $urandom_range(stall_odds - 1, 0) == 0)
					stall_left = $urandom_range(10, 1);
			end
		end
	end

	// watchdog: ends the run once nothing has moved for too long
	initial begin
		do
			@(negedge clk);
		while (quiet_cycles < QUIET_LIMIT);
		$display("framed_pair_deframer_smoother_core verification failed");
		$finish;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic plan_frame(input logic [BYTE_W-1:0] b0, input logic [BYTE_W-1:0] b1,
			input logic [BYTE_W-1:0] b2, input logic [BYTE_W-1:0] b3);
		byte_plan.push_back(b0);
		byte_plan.push_back(b1);
		byte_plan.push_back(b2);
		byte_plan.push_back(b3);
	endtask

	// waits until every byte is taken and every average has come back,
	// then lets the pipeline settle
	task automatic wait_idle();
		do
			@(posedge clk);
		while (byte_plan.size() != 0 || rx_if.valid || avg_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// data byte biased towards the extremes and the markers
	function automatic logic [BYTE_W-1:0] pick_data(input logic [BYTE_W-1:0] open_b,
			input logic [BYTE_W-1:0] close_b);
		case ($urandom_range(9, 0))
		0:       return 8'h00;
		1:       return 8'hff;
		2:       return open_b;
		3:       return close_b;
		default: return BYTE_W'($urandom);
		endcase
	endfunction

	// one setting of the markers, then mostly good frames with broken ones and noise
	task automatic run_phase(input logic [BYTE_W-1:0] open_b, input logic [BYTE_W-1:0] close_b,
			input int s_odds, input int r_odds, input bit poke_unused);
		int                made = 0;
		int                r;
		logic [BYTE_W-1:0] junk;
		write_reg(REG_START_MARKER, open_b);
		write_reg(REG_END_MARKER, close_b);
		if (poke_unused)
			write_reg(CFG_IDX_W'($urandom_range(255, REG_END_MARKER + 1)), BYTE_W'($urandom));
		send_odds = s_odds;
		stall_odds = r_odds;
		while (made < PHASE_WORDS) begin
			r = $urandom_range(99, 0);
			if (r < 70) begin
				plan_frame(open_b, pick_data(open_b, close_b), pick_data(open_b, close_b),
					close_b);
				made += 4;
			end else if (r < 82) begin
				// frame closed by anything but the end marker
				junk = BYTE_W'($urandom);
				while (junk == close_b)
					junk = BYTE_W'($urandom);
				plan_frame(open_b, pick_data(open_b, close_b), pick_data(open_b, close_b), junk);
				made += 4;
			end else begin
				byte_plan.push_back(BYTE_W'($urandom));
				made++;
			end
		end
		// sender holds back here until every average is in
		wait_idle();
	endtask

	initial begin
		logic [BYTE_W-1:0] mark_a;
		logic [BYTE_W-1:0] mark_b;

		// every input known from time zero
		rx_if.valid = 1'b0;
		rx_if.rx_byte = '0;
		res_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		arst_n = 1'b0;

		// predictor state after reset
		hunt_pos = FP_HUNT;
		held_steer = '0;
		held_coll = '0;
		open_mark = OPEN_DEFAULT;
		close_mark = CLOSE_DEFAULT;
		for (int i = 0; i < AVG_LEN; i++) begin
			steer_log[i] = '0;
			coll_log[i] = '0;
		end
		log_slot = 0;
		fails = 0;
		quiet_cycles = 0;
		send_gap = 0;
		stall_left = 0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed words under the reset markers
		send_odds = 5;
		stall_odds = 4;
		byte_plan.push_back(8'h00);                          // noise while hunting
		byte_plan.push_back(8'hff);
		plan_frame(OPEN_DEFAULT, 8'hff, 8'hff, CLOSE_DEFAULT); // largest values
		plan_frame(OPEN_DEFAULT, 8'h00, 8'h00, CLOSE_DEFAULT); // smallest values
		plan_frame(OPEN_DEFAULT, OPEN_DEFAULT, CLOSE_DEFAULT, CLOSE_DEFAULT); // markers as data
		plan_frame(OPEN_DEFAULT, 8'h01, 8'h02, OPEN_DEFAULT); // bad end that is a start byte
		byte_plan.push_back(8'h07);                          // must not close a frame
		byte_plan.push_back(8'h08);
		byte_plan.push_back(CLOSE_DEFAULT);
		plan_frame(OPEN_DEFAULT, 8'hff, 8'hff, CLOSE_DEFAULT);
		wait_idle();

		// marker extremes, equal markers among them
		run_phase(8'h00, 8'h00, 6, 5, 1'b0);
		run_phase(8'hff, 8'hff, 0, 3, 1'b0);
		run_phase(8'h00, 8'hff, 3, 0, 1'b0);
		run_phase(8'hff, 8'h00, 8, 8, 1'b1);

		mark_a = BYTE_W'($urandom);
		mark_b = BYTE_W'($urandom);
		run_phase(mark_a, mark_b, 4, 4, 1'b1);
		mark_a = BYTE_W'($urandom);
		run_phase(mark_a, mark_a, 5, 2, 1'b0);

		// last stretch at full rate on both sides
		send_gap = 0;
		stall_left = 0;
		run_phase(OPEN_DEFAULT, CLOSE_DEFAULT, 0, 0, 1'b1);

		if (fails == 0)
			$display("framed_pair_deframer_smoother_core verification clean");
		else
			$display("framed_pair_deframer_smoother_core verification failed");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+design
design/fpds_pkg.sv
design/fpds_ifs.sv
design/fpds_deframer.sv
design/fpds_smoother.sv
design/framed_pair_deframer_smoother_core.sv
verif/framed_pair_deframer_smoother_core_test.sv
